@@ hdl/lobu_pkg.sv @@
package lobu_pkg;

    localparam int ORDER_SLOTS = 1024;
    localparam int LEVEL_SLOTS = 64;

    localparam int OAW    = $clog2(ORDER_SLOTS);
    localparam int LAW    = $clog2(LEVEL_SLOTS);
    localparam int PIDX_W = (OAW > LAW + 1) ? OAW : LAW + 1;
    localparam int CNT_W  = PIDX_W + 1;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_DELETE  = 3'd1,
        OP_CANCEL  = 3'd2,
        OP_EXECUTE = 3'd3,
        OP_REPLACE = 3'd4
    } t_op;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic        used;
        logic        side;
        logic [63:0] key;
        logic [31:0] price;
        logic [31:0] rem;
    } t_order;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
    } t_level;

    localparam int ORDER_W = $bits(t_order);
    localparam int LEVEL_W = $bits(t_level);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OSCAN,
        S_LSCAN,
        S_WRITE,
        S_BEST,
        S_DONE
    } t_state;

endpackage

@@ hdl/lobu_ram.sv @@
module lobu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/limit_order_book_update_core.sv @@
// Channel   Direction  Handshake                    Payload
// command   in         start high while busy low    i_operation .. i_qty
// result    out        o_done high for one cycle    o_status .. o_volume_total
//
// One shared scan engine walks the order memory, then one side of the level
// memory, then both sides of the level memory for the best prices.
// A replace of a live order walks the order and level memories twice; undefined
// codes go straight to the best price scan. The scans read one memory word per cycle.
// After reset a clearing pass over the order memory runs with busy high.
// Results cannot be held off: o_done marks each one for exactly one cycle.
module limit_order_book_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_order_ref,
    input  logic [63:0] i_new_ref,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_qty,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_bid_valid,
    output logic [31:0] o_best_bid_price,
    output logic [31:0] o_best_bid_qty,
    output logic        o_ask_valid,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_qty,
    output logic [31:0] o_last_trade_price,
    output logic [31:0] o_last_trade_qty,
    output logic [63:0] o_volume_total
);
    import lobu_pkg::*;

    // sequencer and scan engine
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pv, n_pv;
    logic [PIDX_W-1:0]   r_pidx, n_pidx;
    logic                r_second, n_second;
    logic                r_ladd, n_ladd;
    logic [2*LEVEL_SLOTS-1:0] r_lused, n_lused;

    // item context
    logic [2:0]  r_op, n_op;
    logic [63:0] r_key, n_key;
    logic [63:0] r_nref, n_nref;
    logic        r_side, n_side;
    logic [31:0] r_price, n_price;
    logic [31:0] r_qty, n_qty;
    logic [31:0] r_lprice, n_lprice;
    logic [31:0] r_amt, n_amt;
    logic [1:0]  r_status, n_status;

    // order scan results
    logic           r_ohit, n_ohit;
    logic           r_ofree, n_ofree;
    logic [OAW-1:0] r_oidx, n_oidx;
    logic [OAW-1:0] r_fidx, n_fidx;
    logic           r_hside, n_hside;
    logic [31:0]    r_hprice, n_hprice;
    logic [31:0]    r_hrem, n_hrem;

    // level scan results
    logic           r_lhit, n_lhit;
    logic           r_lfree, n_lfree;
    logic [LAW-1:0] r_lidx, n_lidx;
    logic [LAW-1:0] r_lfidx, n_lfidx;
    logic [31:0]    r_lq, n_lq;

    // trade statistics and best prices
    logic [31:0] r_tp, n_tp;
    logic [31:0] r_tq, n_tq;
    logic [63:0] r_vol, n_vol;
    logic        r_bv, n_bv;
    logic [31:0] r_bp, n_bp;
    logic [31:0] r_bq, n_bq;
    logic        r_av, n_av;
    logic [31:0] r_ap, n_ap;
    logic [31:0] r_aq, n_aq;

    // memory ports
    logic               ord_we;
    logic [OAW-1:0]     ord_waddr;
    t_order             ord_wdata;
    logic [ORDER_W-1:0] ord_rdata;
    logic               lvl_we;
    logic [LAW:0]       lvl_waddr;
    t_level             lvl_wdata;
    logic [LAW:0]       lvl_raddr;
    logic [LEVEL_W-1:0] lvl_rdata;

    t_order           o_rd;
    t_level           l_rd;
    logic [CNT_W-1:0] scan_lim;
    logic             scan_end;
    logic             clear_last;
    logic             add_phase;
    logic             lu_side;
    logic             lu_best;
    logic [31:0]      rm_q;
    logic [31:0]      rem_left;
    logic             keep_used;

    lobu_ram #(.WIDTH(ORDER_W), .DEPTH(ORDER_SLOTS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (r_cnt[OAW-1:0]),
        .o_rdata (ord_rdata)
    );

    // level memory: upper address bit selects the ask side
    lobu_ram #(.WIDTH(LEVEL_W), .DEPTH(2 * LEVEL_SLOTS)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    assign o_rd       = t_order'(ord_rdata);
    assign l_rd       = t_level'(lvl_rdata);
    assign lvl_raddr  = (r_state == S_BEST) ? r_cnt[LAW:0] : {r_side, r_cnt[LAW-1:0]};
    assign clear_last = (r_cnt == CNT_W'(ORDER_SLOTS - 1));
    assign add_phase  = (r_op == OP_ADD) || r_second;
    assign lu_side    = r_lused[{r_side, r_pidx[LAW-1:0]}];
    assign lu_best    = r_lused[r_pidx[LAW:0]];
    assign rm_q       = (r_lq > r_amt) ? (r_lq - r_amt) : 32'd0;
    assign rem_left   = r_hrem - r_amt;
    assign keep_used  = ((r_op == OP_CANCEL) || (r_op == OP_EXECUTE)) && (rem_left != 32'd0);

    always_comb begin
        unique case (r_state)
            S_OSCAN: scan_lim = CNT_W'(ORDER_SLOTS);
            S_LSCAN: scan_lim = CNT_W'(LEVEL_SLOTS);
            default: scan_lim = CNT_W'(2 * LEVEL_SLOTS);
        endcase
    end

    assign scan_end = (r_cnt == scan_lim) && !r_pv;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clear_last) begin
                n_state = S_IDLE;
            end
            S_IDLE: if (start) begin
                n_state = (i_operation > OP_REPLACE) ? S_BEST : S_OSCAN;
            end
            S_OSCAN: if (scan_end) begin
                if (add_phase) begin
                    n_state = (r_ohit || r_ofree) ? S_LSCAN : S_BEST;
                end else begin
                    n_state = r_ohit ? S_LSCAN : S_BEST;
                end
            end
            S_LSCAN: if (scan_end) begin
                n_state = (!r_ladd || r_lhit || r_lfree) ? S_WRITE : S_BEST;
            end
            S_WRITE: n_state = (!r_ladd && r_op == OP_REPLACE) ? S_OSCAN : S_BEST;
            S_BEST: if (scan_end) begin
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cnt = r_cnt;       n_pv = r_pv;         n_pidx = r_pidx;
        n_second = r_second; n_ladd = r_ladd;     n_lused = r_lused;
        n_op = r_op;         n_key = r_key;       n_nref = r_nref;
        n_side = r_side;     n_price = r_price;   n_qty = r_qty;
        n_lprice = r_lprice; n_amt = r_amt;       n_status = r_status;
        n_ohit = r_ohit;     n_ofree = r_ofree;   n_oidx = r_oidx;
        n_fidx = r_fidx;     n_hside = r_hside;   n_hprice = r_hprice;
        n_hrem = r_hrem;     n_lhit = r_lhit;     n_lfree = r_lfree;
        n_lidx = r_lidx;     n_lfidx = r_lfidx;   n_lq = r_lq;
        n_tp = r_tp;         n_tq = r_tq;         n_vol = r_vol;
        n_bv = r_bv;         n_bp = r_bp;         n_bq = r_bq;
        n_av = r_av;         n_ap = r_ap;         n_aq = r_aq;
        ord_we = 1'b0;       ord_waddr = r_oidx;  ord_wdata = '0;
        lvl_we = 1'b0;       lvl_waddr = {r_side, r_lidx};
        lvl_wdata = '0;

        // shared scan stepper: issue one address per cycle, check its registered read data
        if (r_state == S_OSCAN || r_state == S_LSCAN || r_state == S_BEST) begin
            if (r_cnt != scan_lim) begin
                n_cnt  = r_cnt + CNT_W'(1);
                n_pv   = 1'b1;
                n_pidx = r_cnt[PIDX_W-1:0];
            end else begin
                n_pv = 1'b0;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                ord_we    = 1'b1;
                ord_waddr = r_cnt[OAW-1:0];
                n_cnt     = r_cnt + CNT_W'(1);
            end
            S_IDLE: if (start) begin
                n_op     = i_operation;
                n_key    = i_order_ref;
                n_nref   = i_new_ref;
                n_side   = i_side;
                n_price  = i_price;
                n_qty    = i_qty;
                n_status = STAT_OK;
                n_second = 1'b0;
                n_cnt    = '0;
                n_pv     = 1'b0;
                n_ohit   = 1'b0;
                n_ofree  = 1'b0;
                n_bv = 1'b0; n_bp = '0; n_bq = '0;
                n_av = 1'b0; n_ap = '0; n_aq = '0;
            end
            S_OSCAN: begin
                if (r_pv) begin
                    if (o_rd.used && o_rd.key == r_key && !r_ohit) begin
                        n_ohit   = 1'b1;
                        n_oidx   = r_pidx[OAW-1:0];
                        n_hside  = o_rd.side;
                        n_hprice = o_rd.price;
                        n_hrem   = o_rd.rem;
                    end
                    if (!o_rd.used && !r_ofree) begin
                        n_ofree = 1'b1;
                        n_fidx  = r_pidx[OAW-1:0];
                    end
                end
                if (scan_end) begin
                    n_cnt   = '0;
                    n_pv    = 1'b0;
                    n_lhit  = 1'b0;
                    n_lfree = 1'b0;
                    if (add_phase) begin
                        // land on the live order with this reference, else the lowest free slot
                        n_oidx   = r_ohit ? r_oidx : r_fidx;
                        n_ladd   = 1'b1;
                        n_lprice = r_price;
                        if (!r_ohit && !r_ofree) begin
                            n_status = STAT_FULL;
                        end
                    end else if (!r_ohit) begin
                        n_status = STAT_UNKNOWN;
                    end else begin
                        n_ladd   = 1'b0;
                        n_side   = r_hside;
                        n_lprice = r_hprice;
                        if (r_op == OP_CANCEL || r_op == OP_EXECUTE) begin
                            n_amt = (r_qty < r_hrem) ? r_qty : r_hrem;
                        end else begin
                            n_amt = r_hrem;
                        end
                        if (r_op == OP_EXECUTE) begin
                            n_tp  = r_hprice;
                            n_tq  = n_amt;
                            n_vol = r_vol + {32'd0, n_amt};
                        end
                    end
                end
            end
            S_LSCAN: begin
                if (r_pv) begin
                    if (lu_side && l_rd.price == r_lprice && !r_lhit) begin
                        n_lhit = 1'b1;
                        n_lidx = r_pidx[LAW-1:0];
                        n_lq   = l_rd.qty;
                    end
                    if (!lu_side && !r_lfree) begin
                        n_lfree = 1'b1;
                        n_lfidx = r_pidx[LAW-1:0];
                    end
                end
                if (scan_end) begin
                    n_cnt = '0;
                    n_pv  = 1'b0;
                    if (r_ladd && !r_lhit && !r_lfree) begin
                        n_status = STAT_FULL;
                    end
                end
            end
            S_WRITE: begin
                ord_we    = 1'b1;
                ord_waddr = r_oidx;
                n_cnt     = '0;
                n_pv      = 1'b0;
                if (r_ladd) begin
                    ord_wdata = '{used: 1'b1, side: r_side, key: r_key,
                                  price: r_price, rem: r_qty};
                    lvl_we    = 1'b1;
                    lvl_waddr = {r_side, (r_lhit ? r_lidx : r_lfidx)};
                    lvl_wdata = '{price: r_lprice, qty: (r_lhit ? r_lq + r_qty : r_qty)};
                    n_lused[{r_side, (r_lhit ? r_lidx : r_lfidx)}] = 1'b1;
                    n_status  = STAT_OK;
                end else begin
                    ord_wdata = '{used: keep_used, side: r_hside, key: r_key,
                                  price: r_hprice, rem: rem_left};
                    if (r_lhit) begin
                        lvl_we    = 1'b1;
                        lvl_waddr = {r_side, r_lidx};
                        lvl_wdata = '{price: r_lprice, qty: rm_q};
                        if (rm_q == 32'd0) begin
                            n_lused[{r_side, r_lidx}] = 1'b0;
                        end
                    end
                    if (r_op == OP_REPLACE) begin
                        // old order gone: now add the new reference on the old side
                        n_second = 1'b1;
                        n_key    = r_nref;
                        n_ohit   = 1'b0;
                        n_ofree  = 1'b0;
                    end
                end
            end
            S_BEST: begin
                if (r_pv && lu_best) begin
                    if (!r_pidx[LAW]) begin
                        if (!r_bv || l_rd.price > r_bp) begin
                            n_bv = 1'b1;
                            n_bp = l_rd.price;
                            n_bq = l_rd.qty;
                        end
                    end else begin
                        if (!r_av || l_rd.price < r_ap) begin
                            n_av = 1'b1;
                            n_ap = l_rd.price;
                            n_aq = l_rd.qty;
                        end
                    end
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_second <= 1'b0;
            r_ladd   <= 1'b0;
            r_lused  <= '0;
            r_ohit   <= 1'b0;
            r_ofree  <= 1'b0;
            r_lhit   <= 1'b0;
            r_lfree  <= 1'b0;
            r_tp     <= '0;
            r_tq     <= '0;
            r_vol    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_second <= n_second;
            r_ladd   <= n_ladd;
            r_lused  <= n_lused;
            r_ohit   <= n_ohit;
            r_ofree  <= n_ofree;
            r_lhit   <= n_lhit;
            r_lfree  <= n_lfree;
            r_tp     <= n_tp;
            r_tq     <= n_tq;
            r_vol    <= n_vol;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_nref   <= n_nref;
        r_side   <= n_side;
        r_price  <= n_price;
        r_qty    <= n_qty;
        r_lprice <= n_lprice;
        r_amt    <= n_amt;
        r_status <= n_status;
        r_oidx   <= n_oidx;
        r_fidx   <= n_fidx;
        r_hside  <= n_hside;
        r_hprice <= n_hprice;
        r_hrem   <= n_hrem;
        r_lidx   <= n_lidx;
        r_lfidx  <= n_lfidx;
        r_lq     <= n_lq;
        r_bv     <= n_bv;
        r_bp     <= n_bp;
        r_bq     <= n_bq;
        r_av     <= n_av;
        r_ap     <= n_ap;
        r_aq     <= n_aq;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = (r_state == S_DONE);
    assign o_status           = r_status;
    assign o_bid_valid        = r_bv;
    assign o_best_bid_price   = r_bp;
    assign o_best_bid_qty     = r_bq;
    assign o_ask_valid        = r_av;
    assign o_best_ask_price   = r_ap;
    assign o_best_ask_qty     = r_aq;
    assign o_last_trade_price = r_tp;
    assign o_last_trade_qty   = r_tq;
    assign o_volume_total     = r_vol;

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("result strobe not followed by idle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_empty_bid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bid_valid) |-> (o_best_bid_price == 32'd0 && o_best_bid_qty == 32'd0))
        else $error("empty bid side shows nonzero level");

    a_empty_ask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ask_valid) |-> (o_best_ask_price == 32'd0 && o_best_ask_qty == 32'd0))
        else $error("empty ask side shows nonzero level");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lobu_pkg::*;

    // Order memory scans dominate the time each item takes.
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM    = 300;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] oref;
        logic [63:0] nref;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_msg;

    typedef struct {
        logic [1:0]  status;
        logic        bv;
        logic [31:0] bp;
        logic [31:0] bq;
        logic        av;
        logic [31:0] ap;
        logic [31:0] aq;
        logic [31:0] tp;
        logic [31:0] tq;
        logic [63:0] vol;
    } t_quote;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [63:0] i_order_ref;
    logic [63:0] i_new_ref;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_qty;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_bid_valid;
    logic [31:0] o_best_bid_price;
    logic [31:0] o_best_bid_qty;
    logic        o_ask_valid;
    logic [31:0] o_best_ask_price;
    logic [31:0] o_best_ask_qty;
    logic [31:0] o_last_trade_price;
    logic [31:0] o_last_trade_qty;
    logic [63:0] o_volume_total;

    limit_order_book_update_core dut (.*);

    // Shadow book: order table, two level tables, trade statistics.
    logic [63:0] bk_key   [ORDER_SLOTS];
    logic [31:0] bk_price [ORDER_SLOTS];
    logic [31:0] bk_rem   [ORDER_SLOTS];
    logic        bk_side  [ORDER_SLOTS];
    logic        bk_used  [ORDER_SLOTS];
    logic [31:0] lv_price [2][LEVEL_SLOTS];
    logic [31:0] lv_qty   [2][LEVEL_SLOTS];
    logic        lv_used  [2][LEVEL_SLOTS];
    logic [31:0] last_px;
    logic [31:0] last_qty;
    logic [63:0] vol_sum;

    t_msg   pending_msgs[$];
    t_quote expected_quotes[$];
    int     mismatches;
    int     n_sent;
    int     n_seen;
    int     stall_cycles;
    bit     taken;
    int     n_full;
    int     n_unknown;
    int     n_exec;

    // Reference pool: small so that messages hit live orders often.
    logic [63:0] ref_pool[16];

    function automatic int find_ord(logic [63:0] r);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (bk_used[i] && bk_key[i] == r) return i;
        return ORDER_SLOTS;
    endfunction

    function automatic void lvl_take(logic s, logic [31:0] p, logic [31:0] q);
        for (int i = 0; i < LEVEL_SLOTS; i++) begin
            if (lv_used[s][i] && lv_price[s][i] == p) begin
                lv_qty[s][i] = (lv_qty[s][i] > q) ? lv_qty[s][i] - q : 32'd0;
                if (lv_qty[s][i] == 0) lv_used[s][i] = 1'b0;
                return;
            end
        end
    endfunction

    function automatic logic [1:0] book_insert(logic [63:0] r, logic s, logic [31:0] p,
                                              logic [31:0] q);
        int o;
        int l;
        o = find_ord(r);
        if (o == ORDER_SLOTS)
            for (int i = 0; i < ORDER_SLOTS; i++)
                if (!bk_used[i]) begin
                    o = i;
                    break;
                end
        if (o == ORDER_SLOTS) return STAT_FULL;
        l = LEVEL_SLOTS;
        for (int i = 0; i < LEVEL_SLOTS; i++)
            if (lv_used[s][i] && lv_price[s][i] == p) begin
                l = i;
                break;
            end
        if (l == LEVEL_SLOTS)
            for (int i = 0; i < LEVEL_SLOTS; i++)
                if (!lv_used[s][i]) begin
                    l = i;
                    break;
                end
        if (l == LEVEL_SLOTS) return STAT_FULL;
        bk_used[o]  = 1'b1;
        bk_key[o]   = r;
        bk_side[o]  = s;
        bk_price[o] = p;
        bk_rem[o]   = q;
        if (!lv_used[s][l]) begin
            lv_used[s][l]  = 1'b1;
            lv_price[s][l] = p;
            lv_qty[s][l]   = 32'd0;
        end
        lv_qty[s][l] += q;
        return STAT_OK;
    endfunction

    // Apply one message to the shadow book and return the quote it leaves.
    function automatic t_quote book_apply(t_msg m);
        t_quote e;
        int o;
        logic [31:0] amt;
        logic s;
        e = '{default: '0};
        e.status = STAT_OK;
        if (m.op == OP_ADD) begin
            e.status = book_insert(m.oref, m.side, m.price, m.qty);
        end else if (m.op <= OP_REPLACE) begin
            o = find_ord(m.oref);
            if (o == ORDER_SLOTS) begin
                e.status = STAT_UNKNOWN;
            end else if (m.op == OP_DELETE) begin
                lvl_take(bk_side[o], bk_price[o], bk_rem[o]);
                bk_used[o] = 1'b0;
            end else if (m.op == OP_CANCEL || m.op == OP_EXECUTE) begin
                amt = (m.qty < bk_rem[o]) ? m.qty : bk_rem[o];
                if (m.op == OP_EXECUTE) begin
                    last_px  = bk_price[o];
                    last_qty = amt;
                    vol_sum += 64'(amt);
                end
                lvl_take(bk_side[o], bk_price[o], amt);
                bk_rem[o] -= amt;
                if (bk_rem[o] == 0) bk_used[o] = 1'b0;
            end else begin
                s = bk_side[o];
                lvl_take(s, bk_price[o], bk_rem[o]);
                bk_used[o] = 1'b0;
                e.status = book_insert(m.nref, s, m.price, m.qty);
            end
        end
        for (int i = 0; i < LEVEL_SLOTS; i++) begin
            if (lv_used[0][i] && (!e.bv || lv_price[0][i] > e.bp)) begin
                e.bv = 1'b1;
                e.bp = lv_price[0][i];
                e.bq = lv_qty[0][i];
            end
            if (lv_used[1][i] && (!e.av || lv_price[1][i] < e.ap)) begin
                e.av = 1'b1;
                e.ap = lv_price[1][i];
                e.aq = lv_qty[1][i];
            end
        end
        e.tp  = last_px;
        e.tq  = last_qty;
        e.vol = vol_sum;
        return e;
    endfunction

    function automatic logic [31:0] rnd32();
        return $urandom();
    endfunction

    function automatic logic [63:0] rnd64();
        return {rnd32(), rnd32()};
    endfunction

    function automatic void push_msg(logic [2:0] op, logic [63:0] r, logic [63:0] n,
                                     logic s, logic [31:0] p, logic [31:0] q);
        t_msg m;
        m.op = op; m.oref = r; m.nref = n; m.side = s; m.price = p; m.qty = q;
        pending_msgs = {pending_msgs, m};
    endfunction

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Driver: present the next item at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (taken) begin
            // Item taken on the last rising edge; the predictor already saw it.
            if (pending_msgs.size() != 0 && (n_sent < 40 || $urandom_range(99, 0) >= 7)) begin
                i_operation <= pending_msgs[0].op;
                i_order_ref <= pending_msgs[0].oref;
                i_new_ref   <= pending_msgs[0].nref;
                i_side      <= pending_msgs[0].side;
                i_price     <= pending_msgs[0].price;
                i_qty       <= pending_msgs[0].qty;
                void'(pending_msgs.pop_front());
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_msgs.size() != 0
                     && (n_sent < 40 || $urandom_range(99, 0) >= 7)) begin
            start       <= 1'b1;
            i_operation <= pending_msgs[0].op;
            i_order_ref <= pending_msgs[0].oref;
            i_new_ref   <= pending_msgs[0].nref;
            i_side      <= pending_msgs[0].side;
            i_price     <= pending_msgs[0].price;
            i_qty       <= pending_msgs[0].qty;
            void'(pending_msgs.pop_front());
        end
    end

    // Monitor: predict on accepted items, check each strobed result.
    always @(posedge i_clk) begin
        t_msg   m;
        t_quote e;
        bit     bad;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (start && !busy) begin
                m.op = i_operation; m.oref = i_order_ref; m.nref = i_new_ref;
                m.side = i_side; m.price = i_price; m.qty = i_qty;
                e = book_apply(m);
                if (e.status == STAT_FULL) n_full++;
                if (e.status == STAT_UNKNOWN) n_unknown++;
                if (m.op == OP_EXECUTE && e.status == STAT_OK) n_exec++;
                expected_quotes = {expected_quotes, e};
                n_sent++;
            end
            if (o_done) begin
                n_seen++;
                if (expected_quotes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with no item pending");
                end else begin
                    e = expected_quotes.pop_front();
                    bad = (o_status !== e.status) || (o_bid_valid !== e.bv)
                        || (o_best_bid_price !== e.bp) || (o_best_bid_qty !== e.bq)
                        || (o_ask_valid !== e.av) || (o_best_ask_price !== e.ap)
                        || (o_best_ask_qty !== e.aq) || (o_last_trade_price !== e.tp)
                        || (o_last_trade_qty !== e.tq) || (o_volume_total !== e.vol);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: exp st=%0d bid=%0d/%0d/%0d ask=%0d/%0d/%0d ",
                                      "tr=%0d/%0d vol=%0d; got st=%0d bid=%0d/%0d/%0d ",
                                      "ask=%0d/%0d/%0d tr=%0d/%0d vol=%0d"},
                                     n_seen, e.status, e.bv, e.bp, e.bq, e.av, e.ap, e.aq,
                                     e.tp, e.tq, e.vol, o_status, o_bid_valid,
                                     o_best_bid_price, o_best_bid_qty, o_ask_valid,
                                     o_best_ask_price, o_best_ask_qty, o_last_trade_price,
                                     o_last_trade_qty, o_volume_total);
                    end
                end
            end
        end
    end

    // Watchdog: the clearing pass after reset also runs with nothing accepted.
    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int kind;
        logic [63:0] r;
        logic [31:0] p;
        i_rst_n = 1'b0; start = 1'b0;
        i_operation = '0; i_order_ref = '0; i_new_ref = '0;
        i_side = 1'b0; i_price = '0; i_qty = '0;
        mismatches = 0; n_sent = 0; n_seen = 0; stall_cycles = 0;
        n_full = 0; n_unknown = 0; n_exec = 0;
        last_px = '0; last_qty = '0; vol_sum = '0;
        for (int i = 0; i < ORDER_SLOTS; i++) bk_used[i] = 1'b0;
        for (int i = 0; i < LEVEL_SLOTS; i++) begin
            lv_used[0][i] = 1'b0;
            lv_used[1][i] = 1'b0;
        end
        ref_pool[0] = '0;
        ref_pool[1] = '1;
        for (int i = 2; i < 16; i++) ref_pool[i] = rnd64();

        // Directed: extremes, each operation and the corner cases.
        push_msg(OP_DELETE, 64'd5, '0, 1'b0, '0, '0);                 // unknown ref
        push_msg(OP_ADD, '0, '0, 1'b0, '0, '0);                       // zero qty bid at 0
        push_msg(OP_ADD, '1, '0, 1'b1, '1, '1);                       // max ask
        push_msg(OP_ADD, 64'd7, '0, 1'b1, '1, 32'd5);                 // level wraps
        push_msg(OP_ADD, 64'd8, '0, 1'b0, 32'd100, 32'd50);
        push_msg(OP_ADD, 64'd8, '0, 1'b0, 32'd200, 32'd30);           // duplicate ref
        push_msg(OP_EXECUTE, 64'd8, '0, 1'b0, '0, 32'd10);
        push_msg(OP_EXECUTE, 64'd8, '0, 1'b0, '0, '1);                // clipped
        push_msg(OP_EXECUTE, '0, '0, 1'b0, '0, 32'd3);                // zero remaining
        push_msg(OP_ADD, 64'd9, '0, 1'b1, 32'd70, 32'd40);
        push_msg(OP_CANCEL, 64'd9, '0, 1'b0, '0, 32'd15);
        push_msg(OP_REPLACE, 64'd9, '1, 1'b0, 32'd60, 32'd22);        // ref clash
        push_msg(OP_REPLACE, 64'd77, 64'd1, 1'b0, '0, '0);
        push_msg(3'd5, '0, '0, 1'b0, '0, '0);
        push_msg(3'd7, '1, '1, 1'b1, '1, '1);
        push_msg(OP_DELETE, 64'd7, '0, 1'b0, '0, '0);
        push_msg(OP_EXECUTE, '1, '0, 1'b0, '0, 32'hFFFF_FFF0);
        // Fill the bid levels past capacity to provoke table full.
        for (int i = 0; i < LEVEL_SLOTS + 2; i++)
            push_msg(OP_ADD, 64'h1000 + i, '0, 1'b0, 32'd1000 + i, 32'd1);
        // Replace into a full level table, then drain it again.
        push_msg(OP_REPLACE, 64'h1000, 64'h2000, 1'b0, 32'd5, 32'd3);
        for (int i = 0; i < LEVEL_SLOTS + 2; i++)
            push_msg(OP_DELETE, 64'h1000 + i, '0, 1'b0, '0, '0);

        // Random: mostly valid operations against a small reference pool.
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(99, 0);
            r = ($urandom_range(9, 0) == 0) ? rnd64() : ref_pool[$urandom_range(15, 0)];
            p = ($urandom_range(9, 0) == 0) ? rnd32() : 32'(1000 + $urandom_range(40, 0));
            if (kind < 35)
                push_msg(OP_ADD, r, rnd64(), 1'($urandom_range(1, 0)), p,
                         ($urandom_range(9, 0) == 0) ? rnd32() : 32'($urandom_range(500, 0)));
            else if (kind < 48)
                push_msg(OP_DELETE, r, rnd64(), 1'($urandom_range(1, 0)), rnd32(), rnd32());
            else if (kind < 63)
                push_msg(OP_CANCEL, r, rnd64(), 1'($urandom_range(1, 0)), rnd32(),
                         ($urandom_range(4, 0) == 0) ? rnd32() : 32'($urandom_range(300, 0)));
            else if (kind < 83)
                push_msg(OP_EXECUTE, r, rnd64(), 1'($urandom_range(1, 0)), rnd32(),
                         ($urandom_range(4, 0) == 0) ? rnd32() : 32'($urandom_range(300, 0)));
            else if (kind < 97)
                push_msg(OP_REPLACE, r, ref_pool[$urandom_range(15, 0)],
                         1'($urandom_range(1, 0)), p, 32'($urandom_range(500, 0)));
            else
                push_msg(3'($urandom_range(7, 5)), rnd64(), rnd64(), 1'($urandom_range(1, 0)),
                         rnd32(), rnd32());
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_msgs.size() == 0 && !start);
        wait (expected_quotes.size() == 0);
        repeat (50) @(posedge i_clk);

        $display("covered %0d messages: %0d executes, %0d unknown refs, %0d table-full",
                 n_sent, n_exec, n_unknown, n_full);
        if (mismatches == 0 && expected_quotes.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lobu_pkg.sv
hdl/lobu_ram.sv
hdl/limit_order_book_update_core.sv
bench/tb_top.sv
